// ===== rtl/msq_pkg.sv =====
// Shared types, constants and the case table for the marching-squares cell segment block.
`timescale 1ns / 1ps

package msq_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 10;
    localparam int HEIGHT_W = 16;
    localparam int EDGE_W   = 21;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = HEIGHT_W + 2;

    // Samples per grid side after reset.
    localparam int GRID_RES_RESET = 256;
    // Smallest usable resolution.
    localparam int GRID_RES_MIN   = 2;

    // Corner bits of the 4-bit case code; a set bit means the corner is inside.
    localparam logic [3:0] CASE_NONE = 4'b0000;
    localparam logic [3:0] CASE_BL   = 4'b0001;
    localparam logic [3:0] CASE_BR   = 4'b0010;
    localparam logic [3:0] CASE_TR   = 4'b0100;
    localparam logic [3:0] CASE_TL   = 4'b1000;
    localparam logic [3:0] CASE_ALL  = 4'b1111;

    // One input beat: a cell and its four corner heights.
    typedef struct packed {
        logic        [COORD_W-1:0]  cell_x;
        logic        [COORD_W-1:0]  cell_y;
        logic signed [HEIGHT_W-1:0] height_bottom_left;
        logic signed [HEIGHT_W-1:0] height_bottom_right;
        logic signed [HEIGHT_W-1:0] height_top_right;
        logic signed [HEIGHT_W-1:0] height_top_left;
    } t_cell_in;

    // One output beat: a segment given by a pair of edge numbers.
    typedef struct packed {
        logic [EDGE_W-1:0] edge_first;
        logic [EDGE_W-1:0] edge_second;
        logic              last_segment;
    } t_seg_out;

    // The edges of a cell: bottom, right, top and left.
    typedef enum logic [1:0] {
        EDGE_BOT,
        EDGE_RGT,
        EDGE_TOP,
        EDGE_LFT
    } t_edge_sel;

    // Which edges each segment of a cell joins.
    typedef struct packed {
        logic      any;
        logic      two;
        t_edge_sel a0;
        t_edge_sel b0;
        t_edge_sel a1;
        t_edge_sel b1;
    } t_seg_plan;

    // Up to two segments of one cell, with a valid bit each after dropping
    // segments whose ends coincide.
    typedef struct packed {
        logic              v0;
        logic              v1;
        logic [EDGE_W-1:0] a0;
        logic [EDGE_W-1:0] b0;
        logic [EDGE_W-1:0] a1;
        logic [EDGE_W-1:0] b1;
    } t_seg_pair;

    // Map a case code and the saddle decision to the edges that are joined.
    function automatic t_seg_plan seg_plan(input logic [3:0] code, input logic center_in);
        t_seg_plan p;
        p.any = 1'b1;
        p.two = 1'b0;
        p.a0  = EDGE_BOT;
        p.b0  = EDGE_LFT;
        p.a1  = EDGE_RGT;
        p.b1  = EDGE_TOP;
        case (code)
            CASE_BL, CASE_ALL ^ CASE_BL: begin
                p.a0 = EDGE_BOT;
                p.b0 = EDGE_LFT;
            end
            CASE_BR, CASE_ALL ^ CASE_BR: begin
                p.a0 = EDGE_BOT;
                p.b0 = EDGE_RGT;
            end
            CASE_BL | CASE_BR, CASE_TR | CASE_TL: begin
                p.a0 = EDGE_LFT;
                p.b0 = EDGE_RGT;
            end
            CASE_TR, CASE_ALL ^ CASE_TR: begin
                p.a0 = EDGE_RGT;
                p.b0 = EDGE_TOP;
            end
            CASE_BR | CASE_TR, CASE_BL | CASE_TL: begin
                p.a0 = EDGE_BOT;
                p.b0 = EDGE_TOP;
            end
            CASE_ALL ^ CASE_TL, CASE_TL: begin
                p.a0 = EDGE_LFT;
                p.b0 = EDGE_TOP;
            end
            CASE_BL | CASE_TR: begin
                p.two = 1'b1;
                if (center_in) begin
                    p.a0 = EDGE_BOT;
                    p.b0 = EDGE_RGT;
                    p.a1 = EDGE_TOP;
                    p.b1 = EDGE_LFT;
                end else begin
                    p.a0 = EDGE_BOT;
                    p.b0 = EDGE_LFT;
                    p.a1 = EDGE_RGT;
                    p.b1 = EDGE_TOP;
                end
            end
            CASE_BR | CASE_TL: begin
                p.two = 1'b1;
                if (center_in) begin
                    p.a0 = EDGE_BOT;
                    p.b0 = EDGE_LFT;
                    p.a1 = EDGE_RGT;
                    p.b1 = EDGE_TOP;
                end else begin
                    p.a0 = EDGE_BOT;
                    p.b0 = EDGE_RGT;
                    p.a1 = EDGE_TOP;
                    p.b1 = EDGE_LFT;
                end
            end
            default: begin
                // Flat cell, all corners on one side: no contour crosses it.
                p.any = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/msq_seg_gen.sv =====
// Edge numbering and case classification for one registered grid cell.
`timescale 1ns / 1ps

module msq_seg_gen #(
    parameter int RES_W = 11
) (
    input  msq_pkg::t_cell_in              i_cell,
    input  logic [RES_W-1:0]               i_res_m1,
    input  logic [msq_pkg::EDGE_W-1:0]     i_vbase,
    output msq_pkg::t_seg_pair             o_segs
);

    localparam int PROD_W = RES_W + msq_pkg::COORD_W;

    logic [3:0]                        code;
    logic signed [msq_pkg::SUM_W-1:0]  corner_sum;
    logic                              center_in;
    logic [PROD_W-1:0]                 row_prod;
    logic [msq_pkg::EDGE_W-1:0]        row_base;
    logic [msq_pkg::EDGE_W-1:0]        key_bot;
    logic [msq_pkg::EDGE_W-1:0]        key_top;
    logic [msq_pkg::EDGE_W-1:0]        key_lft;
    logic [msq_pkg::EDGE_W-1:0]        key_rgt;
    msq_pkg::t_seg_plan                plan;

    // A corner at zero or above counts as inside.
    assign code = {~i_cell.height_top_left[msq_pkg::HEIGHT_W-1],
                   ~i_cell.height_top_right[msq_pkg::HEIGHT_W-1],
                   ~i_cell.height_bottom_right[msq_pkg::HEIGHT_W-1],
                   ~i_cell.height_bottom_left[msq_pkg::HEIGHT_W-1]};

    // The saddle decision uses the corner sum, two bits wider than a height.
    assign corner_sum = msq_pkg::SUM_W'(i_cell.height_bottom_left)
                      + msq_pkg::SUM_W'(i_cell.height_bottom_right)
                      + msq_pkg::SUM_W'(i_cell.height_top_right)
                      + msq_pkg::SUM_W'(i_cell.height_top_left);
    assign center_in  = ~corner_sum[msq_pkg::SUM_W-1];

    // Edge numbers wrap to the edge width. With R the resolution,
    // y*R = y*(R-1) + y, so one product serves both edge families.
    assign row_prod = PROD_W'(i_cell.cell_y) * PROD_W'(i_res_m1);
    assign row_base = msq_pkg::EDGE_W'(row_prod);
    assign key_bot  = row_base + msq_pkg::EDGE_W'(i_cell.cell_x);
    assign key_top  = key_bot + msq_pkg::EDGE_W'(i_res_m1);
    assign key_lft  = i_vbase + key_bot + msq_pkg::EDGE_W'(i_cell.cell_y);
    assign key_rgt  = key_lft + msq_pkg::EDGE_W'(1);

    assign plan = msq_pkg::seg_plan(code, center_in);

    function automatic logic [msq_pkg::EDGE_W-1:0] pick(
        input msq_pkg::t_edge_sel sel,
        input logic [msq_pkg::EDGE_W-1:0] bot,
        input logic [msq_pkg::EDGE_W-1:0] rgt,
        input logic [msq_pkg::EDGE_W-1:0] top,
        input logic [msq_pkg::EDGE_W-1:0] lft
    );
        logic [msq_pkg::EDGE_W-1:0] k;
        case (sel)
            msq_pkg::EDGE_BOT: k = bot;
            msq_pkg::EDGE_RGT: k = rgt;
            msq_pkg::EDGE_TOP: k = top;
            msq_pkg::EDGE_LFT: k = lft;
            default:           k = bot;
        endcase
        return k;
    endfunction

    // Resolve the edge numbers and drop segments whose two ends coincide.
    always_comb begin
        o_segs.a0 = pick(plan.a0, key_bot, key_rgt, key_top, key_lft);
        o_segs.b0 = pick(plan.b0, key_bot, key_rgt, key_top, key_lft);
        o_segs.a1 = pick(plan.a1, key_bot, key_rgt, key_top, key_lft);
        o_segs.b1 = pick(plan.b1, key_bot, key_rgt, key_top, key_lft);
        o_segs.v0 = plan.any && (o_segs.a0 != o_segs.b0);
        o_segs.v1 = plan.any && plan.two && (o_segs.a1 != o_segs.b1);
    end

endmodule

// ===== rtl/marching_squares_cell_segments_top.sv =====
// Top level of the marching-squares cell segment block: cell register, output register, config.
// Each accepted cell yields zero, one or two segment beats on the output channel. A cell is
// taken every cycle while the output keeps up and no saddle cell holds the cell register; it
// sits in the cell register, where edge numbers are formed by one product of the row and the
// resolution minus one, and its segment then moves into the output register, from which it is
// offered on the output. A saddle cell with two segments holds the cell register until its
// second segment is sent; flat cells and cells whose segments all collapse leave nothing on
// the output. A resolution write is clamped to the range from two to MAX_RESOLUTION and its
// derived terms are ready on the next cycle.
`timescale 1ns / 1ps

module marching_squares_cell_segments_top #(
    parameter int MAX_RESOLUTION = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  msq_pkg::t_cell_in           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output msq_pkg::t_seg_out           o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [msq_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int RES_W       = $clog2(MAX_RESOLUTION + 1);
    localparam int CMP_W       = (RES_W > msq_pkg::CFG_W) ? RES_W : msq_pkg::CFG_W;
    localparam int RESET_RES   = (msq_pkg::GRID_RES_RESET > MAX_RESOLUTION)
                               ? MAX_RESOLUTION : msq_pkg::GRID_RES_RESET;
    localparam int RESET_VBASE = (RESET_RES * (RESET_RES - 1)) % (1 << msq_pkg::EDGE_W);

    // Derived resolution terms, kept from the last write.
    logic [RES_W-1:0]             r_res_m1;
    logic [msq_pkg::EDGE_W-1:0]   r_vbase;
    logic [CMP_W-1:0]             cfg_ext;
    logic [RES_W-1:0]             cfg_eff;
    logic [RES_W-1:0]             n_res_m1;
    logic [2*RES_W-1:0]           n_vbase_prod;

    // Cell register and output register.
    logic                         r_s1_valid;
    logic                         r_s1_phase;
    msq_pkg::t_cell_in            r_s1_cell;
    logic                         r_out_valid;
    msq_pkg::t_seg_out            r_out_data;

    msq_pkg::t_seg_pair           segs;
    logic                         out_free;
    logic                         cur_valid;
    logic                         cur_last;
    logic [msq_pkg::EDGE_W-1:0]   cur_first;
    logic [msq_pkg::EDGE_W-1:0]   cur_second;
    logic                         s1_emit;
    logic                         s1_done;
    logic                         in_accept;

    // Clamp the written resolution and form R-1 and R*(R-1).
    always_comb begin
        cfg_ext = CMP_W'(i_cfg_data);
        if (cfg_ext < CMP_W'(msq_pkg::GRID_RES_MIN)) begin
            cfg_eff = RES_W'(msq_pkg::GRID_RES_MIN);
        end else if (cfg_ext > CMP_W'(MAX_RESOLUTION)) begin
            cfg_eff = RES_W'(MAX_RESOLUTION);
        end else begin
            cfg_eff = RES_W'(cfg_ext);
        end
        n_res_m1     = cfg_eff - RES_W'(1);
        n_vbase_prod = (2*RES_W)'(cfg_eff) * (2*RES_W)'(n_res_m1);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_m1 <= RES_W'(RESET_RES - 1);
            r_vbase  <= msq_pkg::EDGE_W'(RESET_VBASE);
        end else if (i_cfg_valid) begin
            r_res_m1 <= n_res_m1;
            r_vbase  <= msq_pkg::EDGE_W'(n_vbase_prod);
        end
    end

    // Segment generation for the cell in the cell register.
    msq_seg_gen #(
        .RES_W (RES_W)
    ) u_seg_gen (
        .i_cell   (r_s1_cell),
        .i_res_m1 (r_res_m1),
        .i_vbase  (r_vbase),
        .o_segs   (segs)
    );

    // Pick the segment to send: the first valid one, or the second once the first is out.
    always_comb begin
        if (r_s1_phase) begin
            cur_valid  = 1'b1;
            cur_first  = segs.a1;
            cur_second = segs.b1;
        end else if (segs.v0) begin
            cur_valid  = 1'b1;
            cur_first  = segs.a0;
            cur_second = segs.b0;
        end else begin
            cur_valid  = segs.v1;
            cur_first  = segs.a1;
            cur_second = segs.b1;
        end
        cur_last = r_s1_phase || !(segs.v0 && segs.v1);
    end

    // Handshake: the cell register frees once its final beat moves on, or at once if it has none.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_emit    = r_s1_valid && cur_valid && out_free;
    assign s1_done    = r_s1_valid && (!cur_valid || (out_free && cur_last));
    assign o_in_ready = !r_s1_valid || s1_done;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_s1_phase <= 1'b0;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (s1_emit) begin
            r_s1_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cell <= i_in_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_data.edge_first   <= cur_first;
            r_out_data.edge_second  <= cur_second;
            r_out_data.last_segment <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The second-segment phase only exists with a cell held.
    a_phase_needs_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_phase |-> r_s1_valid)
        else $error("second-segment phase set with no cell held");

    // Sending the first of two segments holds the cell for its second one.
    a_first_of_two_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_emit && !cur_last) |=> (r_s1_valid && r_s1_phase))
        else $error("cell released before its second segment");

    // A beat sent from the second-segment phase always closes the cell.
    a_phase_beat_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_emit && r_s1_phase) |=> (o_out_valid && o_out_data.last_segment))
        else $error("second segment not marked as last");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench: random and directed cells against a built-in segment predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int          MAX_RES       = 1024;
    localparam int unsigned EDGE_MASK     = (1 << msq_pkg::EDGE_W) - 1;
    localparam int          CELLS_PER_RES = 145;
    localparam int          HOLD_AT       = 380;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 8;

    // Clock, reset and the signals around the block.
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    msq_pkg::t_cell_in          in_data   = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [msq_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    msq_pkg::t_seg_out          o_out_data;
    logic                       o_cfg_ready;

    // Stimulus and scoreboard state.
    msq_pkg::t_cell_in          pending_cells[$];
    msq_pkg::t_seg_out          expected_segments[$];
    logic [msq_pkg::CFG_W-1:0]  grid_res        = msq_pkg::CFG_W'(msq_pkg::GRID_RES_RESET);
    int                         send_idle_pct   = 0;
    int                         recv_idle_pct   = 0;
    int                         cells_accepted  = 0;
    int                         two_seg_cells   = 0;
    int                         silent_cells    = 0;
    int                         segments_seen   = 0;
    int                         error_count     = 0;
    int                         hold_left       = 0;
    logic                       hold_done       = 1'b0;

    marching_squares_cell_segments_top #(
        .MAX_RESOLUTION(MAX_RES)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Resolution as the block uses it, clamped to the supported range.
    function automatic int unsigned effective_resolution(
        input logic [msq_pkg::CFG_W-1:0] res_cfg
    );
        if (res_cfg < msq_pkg::GRID_RES_MIN) return msq_pkg::GRID_RES_MIN;
        if (res_cfg > MAX_RES) return MAX_RES;
        return res_cfg;
    endfunction

    // Segments that one cell produces at a given resolution setting; returns their count.
    function automatic int cell_segments(input msq_pkg::t_cell_in c,
                                         input logic [msq_pkg::CFG_W-1:0] res_cfg,
                                         output msq_pkg::t_seg_out [1:0] segs);
        int unsigned r, cx, cy, bot, top, lft, rgt;
        int unsigned ends_a[2], ends_b[2];
        int          hbl, hbr, htr, htl, planned, n;
        logic [3:0]  code;
        logic        center_in;
        segs = '0;
        r    = effective_resolution(res_cfg);
        cx   = c.cell_x;
        cy   = c.cell_y;
        hbl  = $signed(c.height_bottom_left);
        hbr  = $signed(c.height_bottom_right);
        htr  = $signed(c.height_top_right);
        htl  = $signed(c.height_top_left);
        code = {htl >= 0, htr >= 0, hbr >= 0, hbl >= 0};
        center_in = (hbl + hbr + htr + htl) >= 0;
        // Horizontal edges are numbered first, vertical edges after all of them.
        bot = (cy * (r - 1) + cx) & EDGE_MASK;
        top = ((cy + 1) * (r - 1) + cx) & EDGE_MASK;
        lft = (r * (r - 1) + cy * r + cx) & EDGE_MASK;
        rgt = (r * (r - 1) + cy * r + cx + 1) & EDGE_MASK;
        planned = 1;
        ends_a  = '{bot, rgt};
        ends_b  = '{lft, top};
        case (code)
            msq_pkg::CASE_BL, msq_pkg::CASE_ALL ^ msq_pkg::CASE_BL: begin
                ends_a[0] = bot; ends_b[0] = lft;
            end
            msq_pkg::CASE_BR, msq_pkg::CASE_ALL ^ msq_pkg::CASE_BR: begin
                ends_a[0] = bot; ends_b[0] = rgt;
            end
            msq_pkg::CASE_BL | msq_pkg::CASE_BR, msq_pkg::CASE_TR | msq_pkg::CASE_TL: begin
                ends_a[0] = lft; ends_b[0] = rgt;
            end
            msq_pkg::CASE_TR, msq_pkg::CASE_ALL ^ msq_pkg::CASE_TR: begin
                ends_a[0] = rgt; ends_b[0] = top;
            end
            msq_pkg::CASE_BR | msq_pkg::CASE_TR, msq_pkg::CASE_BL | msq_pkg::CASE_TL: begin
                ends_a[0] = bot; ends_b[0] = top;
            end
            msq_pkg::CASE_TL, msq_pkg::CASE_ALL ^ msq_pkg::CASE_TL: begin
                ends_a[0] = lft; ends_b[0] = top;
            end
            // Saddles: the center sign decides which pair of corners is joined.
            msq_pkg::CASE_BL | msq_pkg::CASE_TR, msq_pkg::CASE_BR | msq_pkg::CASE_TL: begin
                planned = 2;
                if (center_in == (code == (msq_pkg::CASE_BL | msq_pkg::CASE_TR))) begin
                    ends_a = '{bot, top};
                    ends_b = '{rgt, lft};
                end else begin
                    ends_a = '{bot, rgt};
                    ends_b = '{lft, top};
                end
            end
            default: begin
                planned = 0;
            end
        endcase
        // A segment whose two ends are the same edge is dropped.
        n = 0;
        for (int k = 0; k < planned; k++) begin
            if (ends_a[k] != ends_b[k]) begin
                segs[n].edge_first   = ends_a[k][msq_pkg::EDGE_W-1:0];
                segs[n].edge_second  = ends_b[k][msq_pkg::EDGE_W-1:0];
                segs[n].last_segment = 1'b0;
                n++;
            end
        end
        if (n > 0) segs[n-1].last_segment = 1'b1;
        return n;
    endfunction

    // A cell whose inside corners (set bits of the code) get one height, the others another.
    function automatic msq_pkg::t_cell_in shaped_cell(input int unsigned x,
                                                      input int unsigned y,
                                                      input logic [3:0] code, input int ins,
                                                      input int outs);
        msq_pkg::t_cell_in c;
        c.cell_x              = x[msq_pkg::COORD_W-1:0];
        c.cell_y              = y[msq_pkg::COORD_W-1:0];
        c.height_bottom_left  = ((code & msq_pkg::CASE_BL) != 0) ? ins[15:0] : outs[15:0];
        c.height_bottom_right = ((code & msq_pkg::CASE_BR) != 0) ? ins[15:0] : outs[15:0];
        c.height_top_right    = ((code & msq_pkg::CASE_TR) != 0) ? ins[15:0] : outs[15:0];
        c.height_top_left     = ((code & msq_pkg::CASE_TL) != 0) ? ins[15:0] : outs[15:0];
        return c;
    endfunction

    // Heights lean toward the extremes and the values around zero.
    function automatic logic [msq_pkg::HEIGHT_W-1:0] random_height();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly cells inside the grid, some anywhere in the coordinate range; a quarter are
    // saddles, half of them with the corner sum at or just below zero.
    function automatic msq_pkg::t_cell_in random_cell(input logic [msq_pkg::CFG_W-1:0] res_cfg);
        int unsigned       last_coord, x, y;
        int                ins, outs;
        logic [3:0]        code;
        msq_pkg::t_cell_in c;
        last_coord = effective_resolution(res_cfg) - 2;
        x = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(last_coord);
        y = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(last_coord);
        if ($urandom_range(3) == 0) begin
            outs = -1 - int'($urandom_range(32767));
            if ($urandom_range(1) == 0) ins = -outs - int'($urandom_range(1));
            else ins = int'($urandom_range(32767));
            if (ins > 32767) ins = 32767;
            code = ($urandom_range(1) == 0) ? (msq_pkg::CASE_BL | msq_pkg::CASE_TR)
                                            : (msq_pkg::CASE_BR | msq_pkg::CASE_TL);
            c = shaped_cell(x, y, code, ins, outs);
        end else begin
            c = shaped_cell(x, y, msq_pkg::CASE_NONE, 0, 0);
            c.height_bottom_left  = random_height();
            c.height_bottom_right = random_height();
            c.height_top_right    = random_height();
            c.height_top_left     = random_height();
        end
        return c;
    endfunction

    // Cell driver: offers queued cells, predicts the segments of each accepted beat.
    always @(posedge clk) begin
        msq_pkg::t_seg_out [1:0] segs;
        int                      nseg;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                nseg = cell_segments(in_data, grid_res, segs);
                for (int k = 0; k < nseg; k++) expected_segments.push_back(segs[k]);
                if (nseg == 2) two_seg_cells++;
                if (nseg == 0) silent_cells++;
                cells_accepted <= cells_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_cells.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while cells keep coming, so the block backs up.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && cells_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Segment monitor: compares each output beat with the oldest predicted segment.
    always @(posedge clk) begin
        msq_pkg::t_seg_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_segments.size() == 0) begin
                    $error("unexpected segment: edge_first %0d, edge_second %0d, last %0b",
                           o_out_data.edge_first, o_out_data.edge_second,
                           o_out_data.last_segment);
                    error_count++;
                end else begin
                    want = expected_segments.pop_front();
                    check_field("edge_first", want.edge_first, o_out_data.edge_first);
                    check_field("edge_second", want.edge_second, o_out_data.edge_second);
                    check_field("last_segment", want.last_segment, o_out_data.last_segment);
                end
                segments_seen++;
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Wait until every queued cell is taken and every predicted segment has come out.
    task automatic wait_drained();
        while (pending_cells.size() != 0 || in_valid || expected_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_resolution(input logic [msq_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        grid_res   = value;
    endtask

    // Idling rotates: slow receiver, then slow sender, then both at full rate.
    task automatic set_idling(input int phase);
        case (phase % 3)
            0: begin send_idle_pct = 18; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    // Main sequence: directed cells at the reset resolution, then random cells per setting.
    initial begin
        logic [msq_pkg::CFG_W-1:0] res_plan[$];
        logic [3:0]                code;
        res_plan = '{11'd2, 11'd1024, 11'd0, 11'd2047, 11'd1, 11'd3, 11'd1025, 11'd17,
                     11'd512};
        res_plan.push_back(msq_pkg::CFG_W'($urandom_range(2047)));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Every corner pattern, with extreme and near-zero heights on both sides.
        set_idling(0);
        for (int k = 0; k < 16; k++) begin
            code = k[3:0];
            pending_cells.push_back(shaped_cell(k * 60, 1023 - k * 60, code,
                                                k[0] ? 0 : 32767, k[1] ? -1 : -32768));
        end
        // Saddles with the corner sum exactly zero and just below it.
        pending_cells.push_back(shaped_cell(10, 20, msq_pkg::CASE_BL | msq_pkg::CASE_TR,
                                            100, -100));
        pending_cells.push_back(shaped_cell(10, 20, msq_pkg::CASE_BL | msq_pkg::CASE_TR,
                                            0, -1));
        pending_cells.push_back(shaped_cell(30, 40, msq_pkg::CASE_BR | msq_pkg::CASE_TL,
                                            32767, -32768));
        pending_cells.push_back(shaped_cell(30, 40, msq_pkg::CASE_BR | msq_pkg::CASE_TL,
                                            32767, -32767));
        // Corner cells of the grid and coordinates beyond it.
        pending_cells.push_back(shaped_cell(0, 0, msq_pkg::CASE_ALL ^ msq_pkg::CASE_BL,
                                            5, -5));
        pending_cells.push_back(shaped_cell(254, 254, msq_pkg::CASE_BR | msq_pkg::CASE_TR,
                                            1, -1));
        pending_cells.push_back(shaped_cell(1023, 1023, msq_pkg::CASE_BL, 0, -32768));

        for (int p = 0; p < res_plan.size(); p++) begin
            write_resolution(res_plan[p]);
            set_idling(p);
            for (int k = 0; k < CELLS_PER_RES; k++)
                pending_cells.push_back(random_cell(grid_res));
        end

        wait_drained();
        $display("Ran %0d cells over %0d resolution settings: %0d two-segment saddles, %0d flat.",
                 cells_accepted, res_plan.size() + 1, two_seg_cells, silent_cells);
        $display("Checked %0d segment beats, with one %0d-cycle output stall.",
                 segments_seen, HOLD_CYCLES);
        if (error_count == 0 && expected_segments.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/msq_pkg.sv
rtl/msq_seg_gen.sv
rtl/marching_squares_cell_segments_top.sv
tb/testbench.sv
